>>> hdl/cpu_load_store_add_execute_core_assert.svh
// Assertion macros shared by the execute core.
`ifndef CPU_LOAD_STORE_ADD_EXECUTE_CORE_ASSERT_SVH
`define CPU_LOAD_STORE_ADD_EXECUTE_CORE_ASSERT_SVH

// Property that must hold in the cycle after a condition, outside reset.
`define CLS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

// Property that must hold in the same cycle as a condition, outside reset.
`define CLS_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`endif

>>> hdl/cls_pkg.sv
// ---------------------------------------------------------------------------
// cls_pkg
// Shared constants and types for the load/store/add execute core.
// ---------------------------------------------------------------------------
`default_nettype none
package cls_pkg;
  localparam int ADDR_BITS_DEF = 16;
  localparam logic [15:0] HIGH_PAGE = 16'hff00;

  // Memory access kind for one instruction.
  typedef enum logic [2:0] {
    MEM_NONE, MEM_RD1, MEM_WR1, MEM_WR2, MEM_RD2
  } mem_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_SECOND, ST_DONE
  } state_t;
endpackage
`default_nettype wire

>>> hdl/cls_ram.sv
// ---------------------------------------------------------------------------
// cls_ram
// Generic single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module cls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> hdl/cpu_load_store_add_execute_core.sv
// A result beat passes from the DONE state through the live registers (res_p)
// into the output register; PUSH, POP and LD (nn),SP pass SECOND first.
// A new instruction is accepted only in IDLE, after the previous one is written
// back; two-byte accesses need the SECOND state, as the memory has a single port.
// Reset clears A, F, BC, DE, HL and SP; memory content is undefined until written.
// ---------------------------------------------------------------------------
// cpu_load_store_add_execute_core
// Executes one instruction of the LR35902 load, store and add subset per beat.
// ---------------------------------------------------------------------------
`default_nettype none
`include "cpu_load_store_add_execute_core_assert.svh"
module cpu_load_store_add_execute_core #(
  parameter int ADDR_BITS = cls_pkg::ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // op[7:0], imm_hi[15:8], imm_lo[23:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata   // cycles[4:0], illegal[5], reg_a[13:6],
                                     // reg_f[21:14], reg_bc[37:22], reg_de[53:38],
                                     // reg_hl[69:54], reg_sp[85:70], zero fill
);
  // The architectural registers.
  logic [7:0]  ra, rb, rc, rd, re, rh, rl;
  logic [3:0]  rf;
  logic [15:0] sp;

  cls_pkg::state_t st, st_next;

  // Latched instruction.
  logic [7:0] op, n, lo;

  // Memory port.
  logic                 we;
  logic [ADDR_BITS-1:0] maddr;
  logic [7:0]           wdata, rdata;

  cls_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_ram (
    .clk(clk), .we(we), .addr(maddr), .wdata(wdata), .rdata(rdata)
  );

  // A finished instruction first leaves its result in the live registers
  // (res_p set), and moves it into the output register as soon as that is free.
  // A beat waiting in the output register therefore only holds up the input
  // once the following instruction has finished as well.
  logic        out_v;
  logic [4:0]  o_cyc;
  logic        o_ill;
  logic [79:0] o_regs;
  logic        res_p;
  logic [4:0]  p_cyc;
  logic        p_ill;
  logic        move;

  // Decode helpers on an opcode.
  function automatic cls_pkg::mem_kind_t kind_of(input logic [7:0] o);
    cls_pkg::mem_kind_t k;
    k = cls_pkg::MEM_NONE;
    if (o >= 8'h40 && o <= 8'h7f && o != 8'h76) begin
      if (o[5:3] == 3'd6) k = cls_pkg::MEM_WR1;
      else if (o[2:0] == 3'd6) k = cls_pkg::MEM_RD1;
    end else if (o >= 8'h80 && o <= 8'h87) begin
      if (o[2:0] == 3'd6) k = cls_pkg::MEM_RD1;
    end else begin
      case (o)
        8'h36, 8'h02, 8'h12, 8'hea, 8'he2, 8'he0, 8'h22, 8'h32: k = cls_pkg::MEM_WR1;
        8'h0a, 8'h1a, 8'hfa, 8'hf2, 8'hf0, 8'h2a, 8'h3a:        k = cls_pkg::MEM_RD1;
        8'h08, 8'hc5, 8'hd5, 8'he5, 8'hf5:                      k = cls_pkg::MEM_WR2;
        8'hc1, 8'hd1, 8'he1, 8'hf1:                             k = cls_pkg::MEM_RD2;
        default: k = cls_pkg::MEM_NONE;
      endcase
    end
    return k;
  endfunction

  function automatic logic [4:0] cyc_of(input logic [7:0] o);
    logic [4:0] c;
    c = 5'd0;
    if (o >= 8'h40 && o <= 8'h7f && o != 8'h76) begin
      c = (o[5:3] == 3'd6 || o[2:0] == 3'd6) ? 5'd8 : 5'd4;
    end else if (o >= 8'h80 && o <= 8'h87) begin
      c = (o[2:0] == 3'd6) ? 5'd8 : 5'd4;
    end else begin
      case (o)
        8'h06, 8'h0e, 8'h16, 8'h1e, 8'h26, 8'h2e, 8'h3e, 8'h0a, 8'h1a, 8'h02, 8'h12,
        8'hf2, 8'he2, 8'h2a, 8'h3a, 8'h22, 8'h32, 8'hf9, 8'hc6: c = 5'd8;
        8'h36, 8'hf0, 8'he0, 8'h01, 8'h11, 8'h21, 8'h31, 8'hf8,
        8'hc1, 8'hd1, 8'he1, 8'hf1: c = 5'd12;
        8'hfa, 8'hea, 8'hc5, 8'hd5, 8'he5, 8'hf5: c = 5'd16;
        8'h08: c = 5'd20;
        default: c = 5'd0;
      endcase
    end
    return c;
  endfunction

  function automatic logic [7:0] reg_sel(input logic [2:0] i, input logic [7:0] b,
      input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
      input logic [7:0] h, input logic [7:0] l, input logic [7:0] a);
    logic [7:0] v;
    case (i)
      3'd0: v = b;
      3'd1: v = c;
      3'd2: v = d;
      3'd3: v = e;
      3'd4: v = h;
      3'd5: v = l;
      default: v = a;
    endcase
    return v;
  endfunction

  // Issue: the first memory access is driven in the acceptance cycle from the
  // incoming opcode and the current registers, so read data is there next cycle.
  logic [7:0] i_op, i_n, i_lo;
  assign i_op = s_tdata[7:0];
  assign i_n  = s_tdata[15:8];
  assign i_lo = s_tdata[23:16];

  logic accept;
  assign move     = res_p && (!out_v || m_tready);
  assign s_tready = !rst && (st == cls_pkg::ST_IDLE) && (!res_p || !out_v || m_tready);
  assign accept   = s_tvalid && s_tready;

  cls_pkg::mem_kind_t ik, ck;
  assign ik = kind_of(i_op);
  assign ck = kind_of(op);

  logic [15:0] hl, bc, de, nn_i, a1;
  logic [7:0]  w1;
  assign hl   = {rh, rl};
  assign bc   = {rb, rc};
  assign de   = {rd, re};
  assign nn_i = {i_n, i_lo};

  // Address and write data of the first access.
  always_comb begin
    a1 = hl;
    w1 = ra;
    case (i_op)
      8'h0a, 8'h02: a1 = bc;
      8'h1a, 8'h12: a1 = de;
      8'hfa, 8'hea, 8'h08: a1 = nn_i;
      8'hf2, 8'he2: a1 = cls_pkg::HIGH_PAGE | {8'h00, rc};
      8'hf0, 8'he0: a1 = cls_pkg::HIGH_PAGE | {8'h00, i_n};
      8'hc5, 8'hd5, 8'he5, 8'hf5: a1 = sp - 16'd1;
      8'hc1, 8'hd1, 8'he1, 8'hf1: a1 = sp;
      default: a1 = hl;
    endcase
    case (i_op)
      8'h36: w1 = i_n;
      8'h08: w1 = sp[7:0];
      8'hc5: w1 = rb;
      8'hd5: w1 = rd;
      8'he5: w1 = rh;
      8'hf5: w1 = ra;
      default: w1 = (i_op >= 8'h40 && i_op <= 8'h7f)
                    ? reg_sel(i_op[2:0], rb, rc, rd, re, rh, rl, ra) : ra;
    endcase
  end

  // Second access (cycle after acceptance) for two-byte ops. Registers still
  // hold pre-instruction values then, since write-back happens at ST_DONE.
  logic [15:0] a2;
  logic [7:0]  w2;
  always_comb begin
    case (op)
      8'h08: a2 = {n, lo} + 16'd1;
      8'hc1, 8'hd1, 8'he1, 8'hf1: a2 = sp + 16'd1;
      default: a2 = sp - 16'd2;
    endcase
    case (op)
      8'h08: w2 = sp[15:8];
      8'hc5: w2 = rc;
      8'hd5: w2 = re;
      8'he5: w2 = rl;
      default: w2 = {rf, 4'h0};
    endcase
  end

  always_comb begin
    we    = 1'b0;
    maddr = a1[ADDR_BITS-1:0];
    wdata = w1;
    if (st == cls_pkg::ST_SECOND) begin
      maddr = a2[ADDR_BITS-1:0];
      wdata = w2;
      we    = (ck == cls_pkg::MEM_WR2);
    end else if (accept) begin
      we = (ik == cls_pkg::MEM_WR1 || ik == cls_pkg::MEM_WR2);
    end
  end

  // Sequencer: IDLE accepts; SECOND does the second byte; DONE writes back.
  always_comb begin
    st_next = st;
    case (st)
      cls_pkg::ST_IDLE:   if (accept) begin
        st_next = (ik == cls_pkg::MEM_WR2 || ik == cls_pkg::MEM_RD2)
                  ? cls_pkg::ST_SECOND : cls_pkg::ST_DONE;
      end
      cls_pkg::ST_SECOND: st_next = cls_pkg::ST_DONE;
      cls_pkg::ST_DONE:   st_next = cls_pkg::ST_IDLE;
      default:            st_next = cls_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= cls_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // First byte read is captured when the second access is under way.
  logic [7:0] byte1;
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= i_op;
      n  <= i_n;
      lo <= i_lo;
    end
    if (st == cls_pkg::ST_SECOND) begin
      byte1 <= rdata;
    end
  end

  // Write-back: compute the new register state from the latched op and the
  // read data (first byte for one-byte reads, second byte for pops).
  logic [7:0] mb, d8;
  logic [8:0] sum;
  logic [4:0] hsum;
  logic [15:0] spx;
  logic [4:0]  sph;
  logic [8:0]  spc;
  assign mb  = rdata;
  assign d8  = (op == 8'hc6) ? n
             : (op[2:0] == 3'd6) ? mb : reg_sel(op[2:0], rb, rc, rd, re, rh, rl, ra);
  assign sum  = {1'b0, ra} + {1'b0, d8};
  assign hsum = {1'b0, ra[3:0]} + {1'b0, d8[3:0]};
  assign spx  = sp + {{8{n[7]}}, n};
  assign sph  = {1'b0, sp[3:0]} + {1'b0, n[3:0]};
  assign spc  = {1'b0, sp[7:0]} + {1'b0, n};

  always_ff @(posedge clk) begin
    if (rst) begin
      ra <= '0; rf <= '0; rb <= '0; rc <= '0; rd <= '0;
      re <= '0; rh <= '0; rl <= '0; sp <= '0;
      out_v <= 1'b0;
      res_p <= 1'b0;
    end else begin
      // The finished result moves from the live registers to the output slot.
      if (move) begin
        out_v  <= 1'b1;
        o_cyc  <= p_cyc;
        o_ill  <= p_ill;
        o_regs <= {sp, rh, rl, rd, re, rb, rc, rf, 4'h0, ra};
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
      if (st == cls_pkg::ST_DONE) begin
        res_p <= 1'b1;
        p_cyc <= cyc_of(op);
        p_ill <= (cyc_of(op) == 5'd0);
        if (op >= 8'h40 && op <= 8'h7f && op != 8'h76) begin
          if (op[5:3] != 3'd6) begin
            case (op[5:3])
              3'd0: rb <= d8;
              3'd1: rc <= d8;
              3'd2: rd <= d8;
              3'd3: re <= d8;
              3'd4: rh <= d8;
              3'd5: rl <= d8;
              default: ra <= d8;
            endcase
          end
        end else if ((op >= 8'h80 && op <= 8'h87) || op == 8'hc6) begin
          ra <= sum[7:0];
          rf <= {(sum[7:0] == 8'd0), 1'b0, hsum[4], sum[8]};
        end else begin
          case (op)
            8'h06: rb <= n;
            8'h0e: rc <= n;
            8'h16: rd <= n;
            8'h1e: re <= n;
            8'h26: rh <= n;
            8'h2e: rl <= n;
            8'h3e: ra <= n;
            8'h0a, 8'h1a, 8'hfa, 8'hf2, 8'hf0: ra <= mb;
            8'h2a: begin ra <= mb; {rh, rl} <= hl + 16'd1; end
            8'h3a: begin ra <= mb; {rh, rl} <= hl - 16'd1; end
            8'h22: {rh, rl} <= hl + 16'd1;
            8'h32: {rh, rl} <= hl - 16'd1;
            8'h01: begin rb <= n; rc <= lo; end
            8'h11: begin rd <= n; re <= lo; end
            8'h21: begin rh <= n; rl <= lo; end
            8'h31: sp <= {n, lo};
            8'hf9: sp <= hl;
            8'hf8: begin
              rf <= {2'b00, sph[4], spc[8]};
              {rh, rl} <= spx;
            end
            8'hc5, 8'hd5, 8'he5, 8'hf5: sp <= sp - 16'd2;
            8'hc1: begin rb <= mb; rc <= byte1; sp <= sp + 16'd2; end
            8'hd1: begin rd <= mb; re <= byte1; sp <= sp + 16'd2; end
            8'he1: begin rh <= mb; rl <= byte1; sp <= sp + 16'd2; end
            8'hf1: begin ra <= mb; rf <= byte1[7:4]; sp <= sp + 16'd2; end
            default: ;
          endcase
        end
      end else if (move) begin
        res_p <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {10'd0, o_regs, o_ill, o_cyc};

  // A finished result never overwrites one still waiting in the live registers.
  `CLS_ASSERT_NOW(a_no_overrun, clk, rst, (st == cls_pkg::ST_DONE), !res_p,
    "result overwritten before taken")
  // Nothing is accepted outside IDLE.
  `CLS_ASSERT_NOW(a_idle_accept, clk, rst, accept, (st == cls_pkg::ST_IDLE),
    "beat accepted while busy")
  // A result is always pending after the write-back state.
  `CLS_ASSERT_NEXT(a_done_valid, clk, rst, (st == cls_pkg::ST_DONE), res_p,
    "no result after write-back")
  // A result beat stays offered until it is taken.
  `CLS_ASSERT_NEXT(a_hold_valid, clk, rst, (m_tvalid && !m_tready), m_tvalid,
    "result beat withdrawn before taken")
endmodule
`default_nettype wire
